/* hw/rtl/pbez_pkg.sv */
`timescale 1ns / 1ps
package pbez_pkg;

    localparam int unsigned MaxPointsDefault = 256;
    localparam int unsigned FracBitsDefault  = 16;

    localparam int unsigned CoordW = 32;
    localparam int unsigned IntvW  = 31;
    localparam int unsigned CountW = 9;
    localparam int unsigned DegW   = 2;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 31;

    localparam logic [CfgIdxW-1:0] CfgDegree   = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgInterval = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgCount    = 2'd2;

    localparam logic ModeWrite = 1'b0;
    localparam logic ModeEval  = 1'b1;

    localparam logic StatusOk       = 1'b0;
    localparam logic StatusTooFew   = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic [7:0]               point_index;
        logic signed [CoordW-1:0] coord_x;
        logic signed [CoordW-1:0] coord_y;
        logic signed [CoordW-1:0] coord_z;
        logic signed [CoordW-1:0] query_time;
    } in_word_t;

    typedef struct packed {
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic signed [CoordW-1:0] pos_z;
        logic [7:0]               segment_used;
        logic                     status;
    } out_word_t;

endpackage

/* hw/rtl/pbez_ram.sv */
`timescale 1ns / 1ps
module pbez_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

/* hw/rtl/piecewise_bezier_evaluator_core.sv */
`timescale 1ns / 1ps
// Path: an evaluate word passes the two front stages, 32 quotient steps, FRAC_BITS
// fraction steps and the address, memory and six blending stages, then the output
// register; a stall holds every stage. Throughput: one word per cycle, write or
// evaluate, while no result is held stalled; write words give no result.
// Reset (aresetn, synchronous, active low) clears the stage valid bits and loads the
// registers with degree 3, interval 1.0 and no points; the point stores are not cleared.
module piecewise_bezier_evaluator_core
    import pbez_pkg::*;
#(
    parameter int unsigned MAX_POINTS = MaxPointsDefault,
    parameter int unsigned FRAC_BITS  = FracBitsDefault
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [pbez_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [pbez_pkg::CfgDataW-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  pbez_pkg::in_word_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output pbez_pkg::out_word_t        m_data
);
    // The stores are written through an index narrower than the field when the
    // table is small, and through a widened index when it is large; only the low
    // eight bits ever arrive from the port.
    localparam int unsigned AW   = $clog2(MAX_POINTS);
    localparam int unsigned SW   = AW + 1;          // segment and point counts
    localparam int unsigned QS   = 32;              // integer quotient steps
    localparam int unsigned NDIV = QS + FRAC_BITS;  // total division steps
    localparam int unsigned LTW  = FRAC_BITS + 1;   // local parameter 0..ONE
    localparam int unsigned RW   = IntvW + 1;       // partial remainder width
    // Front stages: 0 setup, 1 clamp. Then NDIV divider steps. Then back stages:
    // address, memory read, three blend levels (each a multiply then an add).
    localparam int unsigned NBACK = 8;
    localparam int unsigned NST   = 2 + NDIV + NBACK;
    localparam int unsigned CW    = 34;             // blend width: values stay in range

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DegW-1:0]   degree_reg;
    logic [IntvW-1:0]  interval_reg;
    logic [CountW-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg   <= DegW'(3);
            interval_reg <= IntvW'(65536);
            count_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CfgDegree:   degree_reg   <= cfg_wdata[DegW-1:0];
                CfgInterval: interval_reg <= cfg_wdata[IntvW-1:0];
                CfgCount:    count_reg    <= cfg_wdata[CountW-1:0];
                default: ;
            endcase
        end
    end

    // Derived settings must change only while idle: the user's duty, not enforced.
    logic [IntvW-1:0] intv_reg;
    logic [SW-1:0]    cnt_reg;
    logic             too_few;
    logic [SW-1:0]    nseg_reg;
    logic [SW+IntvW-1:0] total;

    logic [SW-1:0] cnt_next;
    logic [SW-1:0] nseg_next;
    logic [SW-1:0] span;

    always_comb begin
        if (32'(count_reg) > 32'(MAX_POINTS)) begin
            cnt_next = SW'(MAX_POINTS);
        end else begin
            cnt_next = SW'(count_reg);
        end
        span = cnt_next - SW'(1);
        // (cnt-1)/degree for degree 1..3: a constant divide per case
        case (degree_reg)
            2'd1:    nseg_next = span;
            2'd2:    nseg_next = span >> 1;
            2'd3:    nseg_next = SW'((32'(span) * 32'd43691) >> 17);
            default: nseg_next = '0;
        endcase
        too_few = (degree_reg == '0) || (cnt_next < SW'(degree_reg) + SW'(1));
    end

    // The registered settings are loaded on the edge after the last write. The status
    // is taken straight from the registers when a word is captured, and the clamp
    // stage, the first user of the registered values, lies behind the capture stage,
    // so even the word that follows a write at once sees the new settings.
    always_ff @(posedge aclk) begin
        intv_reg <= (interval_reg == '0) ? IntvW'(1) : interval_reg;
        cnt_reg  <= cnt_next;
        nseg_reg <= nseg_next;
    end
    assign total = (SW+IntvW)'(nseg_reg) * (SW+IntvW)'(intv_reg);

    // ------------------------------------------------------------------
    // Pipeline control: a global enable; the output stage is a register with
    // the whole pipe stalling while a result is held.
    // ------------------------------------------------------------------
    logic          adv;
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] wr_reg;   // word is a write, travels without a result

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            wr_reg <= {wr_reg[NST-2:0], s_data.mode == ModeWrite};
        end
    end

    // Per-stage payloads
    logic [AW-1:0]        waddr_reg [NST];
    logic                 wok_reg   [NST];
    logic [CoordW-1:0]    wx_reg [NST];
    logic [CoordW-1:0]    wy_reg [NST];
    logic [CoordW-1:0]    wz_reg [NST];
    logic                 few_reg [NST];

    // ------------------------------------------------------------------
    // Stage 0: capture, stage 1: clamp to [0, total]
    // ------------------------------------------------------------------
    logic signed [CoordW-1:0] qt0_reg;
    logic [31:0]              tcl_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            qt0_reg      <= s_data.query_time;
            waddr_reg[0] <= AW'(s_data.point_index);
            wok_reg[0]   <= 32'(s_data.point_index) < 32'(MAX_POINTS);
            wx_reg[0]    <= s_data.coord_x;
            wy_reg[0]    <= s_data.coord_y;
            wz_reg[0]    <= s_data.coord_z;
            few_reg[0]   <= too_few;
            if (qt0_reg[CoordW-1]) begin
                tcl_reg <= '0;
            end else if ((SW+IntvW)'(unsigned'(qt0_reg)) > total) begin
                tcl_reg <= 32'(total);
            end else begin
                tcl_reg <= unsigned'(qt0_reg);
            end
        end
    end

    // Payload shift for write data and status through all stages
    for (genvar g = 1; g < NST; g++) begin : g_pay
        always_ff @(posedge aclk) begin
            if (adv) begin
                waddr_reg[g] <= waddr_reg[g-1];
                wok_reg[g]   <= wok_reg[g-1];
                wx_reg[g]    <= wx_reg[g-1];
                wy_reg[g]    <= wy_reg[g-1];
                wz_reg[g]    <= wz_reg[g-1];
                few_reg[g]   <= few_reg[g-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider: (t << F) / intv, one quotient bit per stage.
    // The first 32 steps give seg, the next FRAC_BITS the local parameter.
    // ------------------------------------------------------------------
    logic [RW-1:0]  rem_reg [NDIV+1];
    logic [31:0]    num_reg [NDIV+1];
    logic [NDIV-1:0] quo_reg [NDIV+1];

    assign rem_reg[0] = '0;
    assign num_reg[0] = tcl_reg;
    assign quo_reg[0] = '0;

    for (genvar d = 0; d < NDIV; d++) begin : g_div
        logic [RW:0] trial;
        logic        inbit;
        logic [RW-1:0] rem_d;
        logic [31:0]   num_d;
        logic [NDIV-1:0] quo_d;
        assign inbit = (d < QS) ? num_reg[d][31] : 1'b0;
        assign trial = {rem_reg[d], inbit} - {2'b00, intv_reg};
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (!trial[RW]) begin
                    rem_d <= trial[RW-1:0];
                end else begin
                    rem_d <= {rem_reg[d][RW-2:0], inbit};
                end
                num_d <= {num_reg[d][30:0], 1'b0};
                quo_d <= {quo_reg[d][NDIV-2:0], !trial[RW]};
            end
        end
        assign rem_reg[d+1] = rem_d;
        assign num_reg[d+1] = num_d;
        assign quo_reg[d+1] = quo_d;
    end

    // The last segment takes the end time: a quotient at or past nseg becomes
    // nseg-1 with the local parameter at ONE.
    logic [NDIV-1:0] qfin;
    logic [31:0]     seg_raw;
    logic [LTW-1:0]  lt_raw;
    logic            seg_over;
    assign qfin     = quo_reg[NDIV];
    assign seg_raw  = qfin[NDIV-1:FRAC_BITS];
    assign lt_raw   = LTW'(qfin[FRAC_BITS-1:0]);
    assign seg_over = seg_raw >= 32'(nseg_reg);

    // ------------------------------------------------------------------
    // Back stage A: segment, local parameter and start address
    // ------------------------------------------------------------------
    localparam int unsigned BA = 2 + NDIV;
    logic [SW-1:0]  seg_a_reg;
    logic [LTW-1:0] lt_a_reg;
    logic [SW+1:0]  start_a_reg;
    logic [SW-1:0]  seg_sel;
    logic [SW+1:0]  start_raw;

    always_comb begin
        seg_sel   = seg_over ? (nseg_reg - SW'(1)) : SW'(seg_raw);
        start_raw = (SW+2)'(seg_sel) * (SW+2)'(degree_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            seg_a_reg <= seg_sel;
            lt_a_reg  <= seg_over ? LTW'(1 << FRAC_BITS) : lt_raw;
            if (start_raw + (SW+2)'(degree_reg) >= (SW+2)'(cnt_reg)) begin
                start_a_reg <= (SW+2)'(cnt_reg) - (SW+2)'(degree_reg) - (SW+2)'(1);
            end else begin
                start_a_reg <= start_raw;
            end
        end
    end

    // ------------------------------------------------------------------
    // Point stores: four banks per axis, one per control point of a segment,
    // each a full copy so that all four points are read in the same cycle.
    // A write word writes when it leaves the address stage, the same place at
    // which an evaluate word reads, so every read sees exactly the writes that
    // were accepted before it.
    // ------------------------------------------------------------------
    logic          mem_we;
    logic [CoordW-1:0] pt_q [3][4];
    logic [AW-1:0] rd_addr [4];
    logic          rd_ok_reg [4];

    assign mem_we = adv && vld_reg[BA] && wr_reg[BA] && wok_reg[BA];

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [SW+1:0] a_full;
        assign a_full     = start_a_reg + (SW+2)'(k);
        assign rd_addr[k] = AW'(a_full);
        always_ff @(posedge aclk) begin
            if (adv) begin
                rd_ok_reg[k] <= a_full < (SW+2)'(MAX_POINTS);
            end
        end
        pbez_ram #(.WIDTH(CoordW), .DEPTH(MAX_POINTS)) u_x (
            .aclk, .wr_en(mem_we), .wr_addr(waddr_reg[BA]), .wr_data(wx_reg[BA]),
            .rd_en(adv), .rd_addr(rd_addr[k]), .rd_data(pt_q[0][k]));
        pbez_ram #(.WIDTH(CoordW), .DEPTH(MAX_POINTS)) u_y (
            .aclk, .wr_en(mem_we), .wr_addr(waddr_reg[BA]), .wr_data(wy_reg[BA]),
            .rd_en(adv), .rd_addr(rd_addr[k]), .rd_data(pt_q[1][k]));
        pbez_ram #(.WIDTH(CoordW), .DEPTH(MAX_POINTS)) u_z (
            .aclk, .wr_en(mem_we), .wr_addr(waddr_reg[BA]), .wr_data(wz_reg[BA]),
            .rd_en(adv), .rd_addr(rd_addr[k]), .rd_data(pt_q[2][k]));
    end

    // Segment and parameter follow the read by one stage.
    logic [SW-1:0]  seg_b_reg;
    logic [LTW-1:0] lt_b_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            seg_b_reg <= seg_a_reg;
            lt_b_reg  <= lt_a_reg;
        end
    end

    // ------------------------------------------------------------------
    // De Casteljau blending: three levels, each a multiply stage and an add
    // stage. Levels above the degree pass the points through unchanged, so
    // the result always lands in lane 0 after the third level.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] lv_reg [4][3][4];   // level inputs (level 0..3)
    logic signed [CW+LTW:0] pr_reg [3][3][4];
    logic [LTW-1:0] lt_l_reg [4];
    logic [SW-1:0]  seg_l_reg [4];
    logic [LTW-1:0] ltp_reg [3];
    logic [SW-1:0]  segp_reg [3];

    for (genvar ax = 0; ax < 3; ax++) begin : g_ax0
        for (genvar k = 0; k < 4; k++) begin : g_k0
            assign lv_reg[0][ax][k] = rd_ok_reg[k] ? CW'(signed'(pt_q[ax][k])) : '0;
        end
    end
    assign lt_l_reg[0]  = lt_b_reg;
    assign seg_l_reg[0] = seg_b_reg;

    for (genvar l = 0; l < 3; l++) begin : g_lvl
        // active when the level index is below the degree
        logic act;
        assign act = 32'(l) < 32'(degree_reg);
        for (genvar ax = 0; ax < 3; ax++) begin : g_ax
            for (genvar k = 0; k < 4; k++) begin : g_k
                logic signed [CW+LTW:0] pmul;
                logic signed [CW-1:0]   pa_reg;
                logic signed [CW-1:0]   nxt_reg;
                logic signed [CW+LTW:0] rnd;
                if (k < 3) begin : g_m
                    assign pmul = (CW+LTW+1)'(lv_reg[l][ax][k+1] - lv_reg[l][ax][k])
                                * (CW+LTW+1)'(signed'({1'b0, lt_l_reg[l]}));
                end else begin : g_z
                    assign pmul = '0;
                end
                assign rnd = pr_reg[l][ax][k] + (CW+LTW+1)'(1 << (FRAC_BITS - 1));
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        pr_reg[l][ax][k] <= pmul;
                        pa_reg <= lv_reg[l][ax][k];
                        if (act && k < 3) begin
                            nxt_reg <= pa_reg + CW'(rnd >>> FRAC_BITS);
                        end else begin
                            nxt_reg <= pa_reg;
                        end
                    end
                end
                assign lv_reg[l+1][ax][k] = nxt_reg;
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                ltp_reg[l]      <= lt_l_reg[l];
                segp_reg[l]     <= seg_l_reg[l];
                lt_l_reg[l+1]   <= ltp_reg[l];
                seg_l_reg[l+1]  <= segp_reg[l];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic          fin_v;
    logic          fin_few;
    assign fin_v   = vld_reg[NST-1] && !wr_reg[NST-1];
    assign fin_few = few_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (adv) begin
            m_valid <= fin_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (fin_few) begin
                m_data <= '{pos_x: '0, pos_y: '0, pos_z: '0, segment_used: '0,
                            status: StatusTooFew};
            end else begin
                m_data.pos_x        <= CoordW'(lv_reg[3][0][0]);
                m_data.pos_y        <= CoordW'(lv_reg[3][1][0]);
                m_data.pos_z        <= CoordW'(lv_reg[3][2][0]);
                m_data.segment_used <= 8'(seg_l_reg[3]);
                m_data.status       <= StatusOk;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && vld_reg[NST-1] && wr_reg[NST-1] |=> !m_valid)
        else $error("write word produced a result");
endmodule
